FILE: src/mavgw_pkg.sv
`default_nettype none

package mavgw_pkg;

    // Window length register
    localparam int WL_BITS = 6;
    localparam int WL_VALUES = 2 ** WL_BITS;
    localparam logic [WL_BITS-1:0] WL_RESET = 6'd16;

    // Running sum and quotient format
    localparam int SUM_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int DVD_BITS = SUM_BITS + FRAC_BITS;
    localparam int STEP_BITS = $clog2(DVD_BITS);

    // Per-item control decided by the front end.
    typedef struct packed {
        logic [WL_BITS-1:0] divisor;
        logic               warm;
        logic               skip_read;
    } t_job_ctl;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_ADD,
        BK_SIGN,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

`default_nettype wire

FILE: src/mavgw_ram.sv
`default_nettype none

module mavgw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/mavgw_front.sv
`default_nettype none

module mavgw_front
    import mavgw_pkg::*;
#(
    parameter int RING_DEPTH = 64,
    parameter int SAMPLE_BITS = 24,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [WL_BITS-1:0]     i_window,
    input  wire logic                   i_block,
    output logic                        o_full,
    output logic                        o_job_valid,
    output logic      [SAMPLE_BITS-1:0] o_job_sample,
    output logic      [AW-1:0]          o_job_wp,
    output logic      [AW-1:0]          o_job_old,
    output t_job_ctl                    o_job_ctl
);

    logic [AW-1:0]      r_wp, n_wp;
    logic [WL_BITS-1:0] r_warm_left, n_warm_left;
    logic [WL_BITS-1:0] w_eff;
    logic [AW-1:0]      wp_adv;
    logic [AW-1:0]      back_tab [WL_VALUES];
    logic [AW-1:0]      back;
    logic [AW-1:0]      old_lo;
    logic [AW:0]        old_hi;
    logic               accept;
    t_job_ctl           ctl;

    // Look-back distance for every window value, reduced modulo the ring depth.
    for (genvar k = 0; k < WL_VALUES; k++) begin : g_back
        assign back_tab[k] = AW'(k % RING_DEPTH);
    end

    assign accept = i_push && !i_block;
    assign w_eff  = (i_window == '0) ? WL_BITS'(1) : i_window;
    assign wp_adv = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign back   = back_tab[w_eff];
    assign old_lo = wp_adv - back;
    assign old_hi = (AW+1)'(wp_adv) + (AW+1)'(RING_DEPTH) - (AW+1)'(back);

    always_comb begin
        n_warm_left   = r_warm_left;
        n_wp          = r_wp;
        ctl.skip_read = (back == '0);
        if (r_warm_left != '0) begin
            ctl.divisor = (r_warm_left < w_eff) ? w_eff - r_warm_left : WL_BITS'(1);
            ctl.warm    = 1'b0;
            if (accept) begin
                n_warm_left = r_warm_left - WL_BITS'(1);
            end
        end else begin
            ctl.divisor = w_eff;
            ctl.warm    = 1'b1;
        end
        if (accept) begin
            n_wp = wp_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_warm_left <= WL_RESET - WL_BITS'(1);
        end else begin
            r_wp        <= n_wp;
            r_warm_left <= n_warm_left;
        end
    end

    assign o_full       = i_block;
    assign o_job_valid  = accept;
    assign o_job_sample = i_sample;
    assign o_job_wp     = wp_adv;
    assign o_job_old    = (wp_adv >= back) ? old_lo : old_hi[AW-1:0];
    assign o_job_ctl    = ctl;

endmodule

`default_nettype wire

FILE: src/mavgw_queue.sv
`default_nettype none

module mavgw_queue #(
    parameter int WIDTH = 40
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/mavgw_back.sv
`default_nettype none

module mavgw_back
    import mavgw_pkg::*;
#(
    parameter int RING_DEPTH = 64,
    parameter int SAMPLE_BITS = 24,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_empty,
    input  wire logic [SAMPLE_BITS-1:0] i_job_sample,
    input  wire logic [AW-1:0]          i_job_wp,
    input  wire logic [AW-1:0]          i_job_old,
    input  t_job_ctl                    i_job_ctl,
    output logic                        o_job_pop,
    output logic                        o_clearing,
    input  wire logic                   i_pop,
    output logic                        o_empty,
    output logic      [SUM_BITS-1:0]    o_average,
    output logic                        o_warmed_up
);

    localparam logic [SUM_BITS-1:0] SAT_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic [SUM_BITS-1:0] SAT_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    t_back_state r_state, n_state;

    logic [AW-1:0]          r_clr_addr;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [AW-1:0]          r_wp;
    logic [AW-1:0]          r_old;
    t_job_ctl               r_ctl;
    logic [SUM_BITS-1:0]    r_sum;
    logic                   r_neg;
    logic [DVD_BITS-1:0]    r_dvd;
    logic [WL_BITS-1:0]     r_rem;
    logic [STEP_BITS-1:0]   r_step;
    logic                   r_out_valid;
    logic [SUM_BITS-1:0]    r_average;
    logic                   r_warm;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    logic signed [SAMPLE_BITS-1:0] new_s;
    logic signed [SAMPLE_BITS-1:0] old_s;
    logic [SUM_BITS-1:0]    sum_nx;
    logic [SUM_BITS-1:0]    mag;
    logic [WL_BITS:0]       rem_sh;
    logic [WL_BITS:0]       rem_sub;
    logic                   q_bit;
    logic                   pos_ovf;
    logic                   neg_ovf;
    logic [SUM_BITS-1:0]    result;
    logic                   out_free;
    logic                   load_out;
    logic                   take_job;

    mavgw_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_old),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: if (r_clr_addr == AW'(RING_DEPTH - 1)) n_state = BK_IDLE;
            BK_IDLE:  if (!i_job_empty) n_state = BK_READ;
            BK_READ:  n_state = BK_ADD;
            BK_ADD:   n_state = BK_SIGN;
            BK_SIGN:  n_state = BK_DIV;
            BK_DIV:   if (r_step == STEP_BITS'(DVD_BITS - 1)) n_state = BK_DONE;
            BK_DONE:  if (out_free) n_state = BK_IDLE;
            default:  n_state = BK_CLEAR;
        endcase
    end

    always_comb begin
        take_job  = (r_state == BK_IDLE) && !i_job_empty;
        ram_we    = (r_state == BK_CLEAR) || (r_state == BK_ADD);
        ram_waddr = (r_state == BK_CLEAR) ? r_clr_addr : r_wp;
        ram_wdata = (r_state == BK_CLEAR) ? '0 : r_sample;
        load_out  = (r_state == BK_DONE) && out_free;
    end

    // When the window is a multiple of the ring depth the removed sample is
    // the one just written, so the value read from the ring is not used.
    assign new_s  = r_sample;
    assign old_s  = r_ctl.skip_read ? r_sample : ram_rdata;
    assign sum_nx = r_sum + SUM_BITS'(new_s) - SUM_BITS'(old_s);
    assign mag    = r_sum[SUM_BITS-1] ? (~r_sum + SUM_BITS'(1)) : r_sum;

    // One restoring step per cycle; the quotient shifts into the dividend.
    assign rem_sh  = {r_rem, r_dvd[DVD_BITS-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_ctl.divisor});
    assign rem_sub = q_bit ? rem_sh - {1'b0, r_ctl.divisor} : rem_sh;

    assign pos_ovf = |r_dvd[DVD_BITS-1:SUM_BITS-1];
    assign neg_ovf = (|r_dvd[DVD_BITS-1:SUM_BITS])
                     || (r_dvd[SUM_BITS-1] && |r_dvd[SUM_BITS-2:0]);

    always_comb begin
        if (r_neg) begin
            result = neg_ovf ? SAT_MIN : (~r_dvd[SUM_BITS-1:0] + SUM_BITS'(1));
        end else begin
            result = pos_ovf ? SAT_MAX : r_dvd[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (r_state == BK_ADD) begin
                r_sum <= sum_nx;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_sample <= i_job_sample;
            r_wp     <= i_job_wp;
            r_old    <= i_job_old;
            r_ctl    <= i_job_ctl;
        end
        if (r_state == BK_SIGN) begin
            r_neg  <= r_sum[SUM_BITS-1];
            r_dvd  <= {mag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == BK_DIV) begin
            r_dvd  <= {r_dvd[DVD_BITS-2:0], q_bit};
            r_rem  <= rem_sub[WL_BITS-1:0];
            r_step <= r_step + STEP_BITS'(1);
        end
        if (load_out) begin
            r_average <= result;
            r_warm    <= r_ctl.warm;
        end
    end

    assign o_job_pop   = take_job;
    assign o_clearing  = (r_state == BK_CLEAR);
    assign o_empty     = !r_out_valid;
    assign o_average   = r_average;
    assign o_warmed_up = r_warm;

    a_rem_below_divisor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_rem < r_ctl.divisor))
        else $error("divider remainder not below divisor");

    a_divisor_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_job |-> (i_job_ctl.divisor != '0))
        else $error("job taken with a zero divisor");

    a_read_apart_from_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BK_ADD) && !r_ctl.skip_read) |-> (r_wp != r_old))
        else $error("ring read and write collide on one item");

    a_no_job_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CLEAR) |-> i_job_empty)
        else $error("job queued while the ring is being cleared");

endmodule

`default_nettype wire

FILE: src/moving_average_warmup_top.sv
// An accepted beat goes into the queue; the back end takes it when idle, reads the ring,
// updates the sum, runs the 40-step serial divider and registers the result, and only
// then takes the next item. Up to two further items are accepted into the queue while
// the back end is busy. Reset is synchronous and active low; afterwards the sample ring
// is cleared at one entry per cycle, during which full stays high.
`default_nettype none

module moving_average_warmup_top
    import mavgw_pkg::*;
#(
    parameter int RING_DEPTH = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        empty,
    input  wire logic                   pop,
    output logic      [SUM_BITS-1:0]    o_average,
    output logic                        o_warmed_up,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [WL_BITS-1:0]     i_cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CTL_BITS = $bits(t_job_ctl);
    localparam int JOB_BITS = SAMPLE_BITS + 2 * AW + CTL_BITS;

    logic [WL_BITS-1:0]     r_window_length;

    logic                   block;
    logic                   job_valid;
    logic [SAMPLE_BITS-1:0] job_sample;
    logic [AW-1:0]          job_wp;
    logic [AW-1:0]          job_old;
    t_job_ctl               job_ctl;

    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [JOB_BITS-1:0]    q_rd_data;
    logic                   clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WL_RESET;
        end else if (i_cfg_valid) begin
            r_window_length <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign block       = q_full || clearing;

    mavgw_front #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_sample     (i_sample),
        .i_window     (r_window_length),
        .i_block      (block),
        .o_full       (full),
        .o_job_valid  (job_valid),
        .o_job_sample (job_sample),
        .o_job_wp     (job_wp),
        .o_job_old    (job_old),
        .o_job_ctl    (job_ctl)
    );

    mavgw_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  ({job_sample, job_wp, job_old, job_ctl}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    mavgw_back #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (q_empty),
        .i_job_sample (q_rd_data[CTL_BITS+2*AW +: SAMPLE_BITS]),
        .i_job_wp     (q_rd_data[CTL_BITS+AW +: AW]),
        .i_job_old    (q_rd_data[CTL_BITS +: AW]),
        .i_job_ctl    (t_job_ctl'(q_rd_data[CTL_BITS-1:0])),
        .o_job_pop    (q_pop),
        .o_clearing   (clearing),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_average    (o_average),
        .o_warmed_up  (o_warmed_up)
    );

endmodule

`default_nettype wire
